>>> rtl/obstacle_bin_hysteresis_steer_assert.svh
// Assertion macros used by the checker file of the steering block.
// Both sample on the rising edge of clock and are switched off while reset is high.
`ifndef OBSTACLE_BIN_HYSTERESIS_STEER_ASSERT_SVH
`define OBSTACLE_BIN_HYSTERESIS_STEER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define OBHS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("obhs check failed");

// Check that cons holds in the cycle after ante.
`define OBHS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("obhs check failed");

`endif

>>> rtl/obhs_pkg.sv
`default_nettype none
package obhs_pkg;

   localparam int NUM_BINS       = 5;
   localparam int DIST_WIDTH     = 12;
   localparam int COUNT_WIDTH    = 2;
   localparam int SPEED_WIDTH    = 8;
   localparam int DEC_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 12;

   // Decision codes
   localparam logic [DEC_WIDTH-1:0] DEC_FORWARD = 2'd0;
   localparam logic [DEC_WIDTH-1:0] DEC_LEFT    = 2'd1;
   localparam logic [DEC_WIDTH-1:0] DEC_RIGHT   = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_DISTANCE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FREE_DISTANCE  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONFIRM_COUNT  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TURN_SPEED     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FORWARD_SPEED  = 3'd4;

   // Register reset values
   localparam logic [DIST_WIDTH-1:0]  RST_BLOCK_DISTANCE = 12'd220;
   localparam logic [DIST_WIDTH-1:0]  RST_FREE_DISTANCE  = 12'd280;
   localparam logic [COUNT_WIDTH-1:0] RST_CONFIRM_COUNT  = 2'd2;
   localparam logic [SPEED_WIDTH-1:0] RST_TURN_SPEED     = 8'd150;
   localparam logic [SPEED_WIDTH-1:0] RST_FORWARD_SPEED  = 8'd190;

   localparam logic [COUNT_WIDTH-1:0] TICKS_MAX = 2'd3;

   typedef struct packed {
      logic [DIST_WIDTH-1:0] dist_0;
      logic [DIST_WIDTH-1:0] dist_1;
      logic [DIST_WIDTH-1:0] dist_2;
      logic [DIST_WIDTH-1:0] dist_3;
      logic [DIST_WIDTH-1:0] dist_4;
   } req_type;

   typedef struct packed {
      logic [DEC_WIDTH-1:0]   decision;
      logic [SPEED_WIDTH-1:0] drive_speed;
      logic [NUM_BINS-1:0]    blocked_mask;
   } rsp_type;

   // Thresholds seen by every bin
   typedef struct packed {
      logic [DIST_WIDTH-1:0]  block_distance;
      logic [DIST_WIDTH-1:0]  free_distance;
      logic [COUNT_WIDTH-1:0] confirm_count;
   } bin_cfg_type;

   // Speeds seen by the steering logic
   typedef struct packed {
      logic [SPEED_WIDTH-1:0] turn_speed;
      logic [SPEED_WIDTH-1:0] forward_speed;
   } steer_cfg_type;

endpackage
`default_nettype wire

>>> rtl/obhs_bin.sv
`default_nettype none
module obhs_bin (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               update,
   input  logic [obhs_pkg::DIST_WIDTH-1:0]    reading,
   input  obhs_pkg::bin_cfg_type              cfg,
   output logic                               blocked_next
);
   import obhs_pkg::*;

   logic                   blocked_ff, blocked_in;
   logic                   pending_ff, pending_in;
   logic [COUNT_WIDTH-1:0] ticks_ff, ticks_in;

   logic                   target;
   logic [COUNT_WIDTH-1:0] ticks_seen;

   // Classify the reading; blocked wins where the thresholds overlap
   always_comb begin
      if (reading < cfg.block_distance) begin
         target = 1'b1;
      end else if (reading > cfg.free_distance) begin
         target = 1'b0;
      end else begin
         target = blocked_ff;
      end
   end

   // Count ticks that ask for the pending state, saturating
   always_comb begin
      if (pending_ff == target) begin
         ticks_seen = (ticks_ff < TICKS_MAX) ? ticks_ff + 2'd1 : ticks_ff;
      end else begin
         ticks_seen = 2'd1;
      end
   end

   // Confirm a change once it has been asked for often enough
   always_comb begin
      blocked_in = blocked_ff;
      pending_in = pending_ff;
      ticks_in   = ticks_ff;
      if (reading != '0) begin
         if (target == blocked_ff) begin
            ticks_in = '0;
         end else begin
            pending_in = target;
            if (ticks_seen >= cfg.confirm_count) begin
               blocked_in = target;
               ticks_in   = '0;
            end else begin
               ticks_in = ticks_seen;
            end
         end
      end
   end

   assign blocked_next = blocked_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= 1'b0;
         pending_ff <= 1'b0;
         ticks_ff   <= '0;
      end else if (update) begin
         blocked_ff <= blocked_in;
         pending_ff <= pending_in;
         ticks_ff   <= ticks_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/obhs_steer.sv
`default_nettype none
module obhs_steer (
   input  obhs_pkg::req_type                 dists,
   input  logic [obhs_pkg::NUM_BINS-1:0]     blocked_mask,
   input  obhs_pkg::steer_cfg_type           cfg,
   output obhs_pkg::rsp_type                 result
);
   import obhs_pkg::*;

   logic [DIST_WIDTH-1:0] room_left;
   logic [DIST_WIDTH-1:0] room_right;

   // Room on each side from the raw readings
   assign room_left  = (dists.dist_1 > dists.dist_3) ? dists.dist_1 : dists.dist_3;
   assign room_right = (dists.dist_2 > dists.dist_4) ? dists.dist_2 : dists.dist_4;

   // Turn if any front bin is blocked; a tie turns right
   always_comb begin
      result.blocked_mask = blocked_mask;
      if (blocked_mask[2:0] != 3'b000) begin
         result.decision    = (room_left > room_right) ? DEC_LEFT : DEC_RIGHT;
         result.drive_speed = cfg.turn_speed;
      end else begin
         result.decision    = DEC_FORWARD;
         result.drive_speed = cfg.forward_speed;
      end
   end

endmodule
`default_nettype wire

>>> rtl/obstacle_bin_hysteresis_steer.sv
// Channel   Direction  Handshake            Carries
// req_      in         req_valid/req_stall  five distances, one per bin (req_type)
// rsp_      out        rsp_valid/rsp_stall  decision, speed, blocked mask (rsp_type)
// csr_      in         csr_wen              register index and data, no read-back
//
// One transaction per cycle while the result side is not stalled; a taken transaction
// passes through the input register and then the result register before its result is valid.
// The bin update sits between the input register and the result register, so the
// per-bin hysteresis state is the only loop and it closes through each bin's own registers.
// Synchronous reset clears bins, pending states, counters and registers to defaults.
// A stalled result holds; req_stall rises only when both registers are full and rsp_stall is high.
`default_nettype none
module obstacle_bin_hysteresis_steer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  obhs_pkg::req_type                      req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output obhs_pkg::rsp_type                      rsp_payload,
   input  logic                                   csr_wen,
   input  logic [obhs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [obhs_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import obhs_pkg::*;

   logic [DIST_WIDTH-1:0]  block_distance_ff, block_distance_in;
   logic [DIST_WIDTH-1:0]  free_distance_ff, free_distance_in;
   logic [COUNT_WIDTH-1:0] confirm_count_ff, confirm_count_in;
   logic [SPEED_WIDTH-1:0] turn_speed_ff, turn_speed_in;
   logic [SPEED_WIDTH-1:0] forward_speed_ff, forward_speed_in;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic                  advance;
   logic                  accept;
   bin_cfg_type           bin_cfg;
   steer_cfg_type         steer_cfg;
   logic [DIST_WIDTH-1:0] bin_dist [NUM_BINS];
   logic [NUM_BINS-1:0]   blocked_next;
   rsp_type               rsp_payload_next;

   // Register writes
   always_comb begin
      block_distance_in = block_distance_ff;
      free_distance_in  = free_distance_ff;
      confirm_count_in  = confirm_count_ff;
      turn_speed_in     = turn_speed_ff;
      forward_speed_in  = forward_speed_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_BLOCK_DISTANCE: block_distance_in = csr_wdata;
            CSR_FREE_DISTANCE:  free_distance_in  = csr_wdata;
            CSR_CONFIRM_COUNT:  confirm_count_in  = csr_wdata[COUNT_WIDTH-1:0];
            CSR_TURN_SPEED:     turn_speed_in     = csr_wdata[SPEED_WIDTH-1:0];
            CSR_FORWARD_SPEED:  forward_speed_in  = csr_wdata[SPEED_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_distance_ff <= RST_BLOCK_DISTANCE;
         free_distance_ff  <= RST_FREE_DISTANCE;
         confirm_count_ff  <= RST_CONFIRM_COUNT;
         turn_speed_ff     <= RST_TURN_SPEED;
         forward_speed_ff  <= RST_FORWARD_SPEED;
      end else begin
         block_distance_ff <= block_distance_in;
         free_distance_ff  <= free_distance_in;
         confirm_count_ff  <= confirm_count_in;
         turn_speed_ff     <= turn_speed_in;
         forward_speed_ff  <= forward_speed_in;
      end
   end

   // Flow control: advance when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      in_data_in   = accept ? req_payload : in_data_ff;
      out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_data_in = rsp_payload_next;
      end
   end

   // Clear valids at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payloads without reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   // Per-bin hysteresis, updated as the transaction moves to the result register
   assign bin_cfg.block_distance = block_distance_ff;
   assign bin_cfg.free_distance  = free_distance_ff;
   assign bin_cfg.confirm_count  = confirm_count_ff;

   assign bin_dist[0] = in_data_ff.dist_0;
   assign bin_dist[1] = in_data_ff.dist_1;
   assign bin_dist[2] = in_data_ff.dist_2;
   assign bin_dist[3] = in_data_ff.dist_3;
   assign bin_dist[4] = in_data_ff.dist_4;

   for (genvar gi = 0; gi < NUM_BINS; gi++) begin : g_bin
      obhs_bin u_bin (
         .clock        (clock),
         .reset        (reset),
         .update       (advance),
         .reading      (bin_dist[gi]),
         .cfg          (bin_cfg),
         .blocked_next (blocked_next[gi])
      );
   end

   // Steering decision from the updated mask
   assign steer_cfg.turn_speed    = turn_speed_ff;
   assign steer_cfg.forward_speed = forward_speed_ff;

   obhs_steer u_steer (
      .dists        (in_data_ff),
      .blocked_mask (blocked_next),
      .cfg          (steer_cfg),
      .result       (rsp_payload_next)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule
`default_nettype wire

>>> rtl/obhs_checker.sv
`default_nettype none
`include "obstacle_bin_hysteresis_steer_assert.svh"
module obhs_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_stall,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  obhs_pkg::rsp_type rsp_payload
);
   import obhs_pkg::*;

   logic front_clear;
   logic goes_forward;

   assign front_clear  = (rsp_payload.blocked_mask[2:0] == 3'b000);
   assign goes_forward = (rsp_payload.decision == DEC_FORWARD);

   // Both sides come out of reset empty and open
   `OBHS_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid && !req_stall)

   // The input side only stalls behind a full, stalled result
   `OBHS_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)

   // Forward exactly when no front bin is blocked
   `OBHS_ASSERT_NOW(a_forward_mask, rsp_valid, front_clear == goes_forward)

   // A stalled result holds
   `OBHS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind obstacle_bin_hysteresis_steer obhs_checker u_obhs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

>>> dv/tb_obstacle_bin_hysteresis_steer.sv
`default_nettype none
module tb_obstacle_bin_hysteresis_steer;
   import obhs_pkg::*;

   // Register index that decodes to nothing
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 3'd7;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 180;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD_CYCLES = 80;

   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic [CSR_INDEX_WIDTH-1:0] reg_index;
      logic [CSR_DATA_WIDTH-1:0]  reg_data;
      req_type                    req;
      bit                         pinned;
      rsp_type                    want;
   } scenario_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_payload;
   logic                       csr_wen = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Predictor copy of the registers
   logic [DIST_WIDTH-1:0]  blk_dist = RST_BLOCK_DISTANCE;
   logic [DIST_WIDTH-1:0]  free_dist = RST_FREE_DISTANCE;
   logic [COUNT_WIDTH-1:0] confirm_cnt = RST_CONFIRM_COUNT;
   logic [SPEED_WIDTH-1:0] turn_spd = RST_TURN_SPEED;
   logic [SPEED_WIDTH-1:0] fwd_spd = RST_FORWARD_SPEED;

   // Predictor copy of the per-bin hysteresis state
   logic                   bin_state [NUM_BINS] = '{default: 1'b0};
   logic                   pend_state [NUM_BINS] = '{default: 1'b0};
   logic [COUNT_WIDTH-1:0] pend_ticks [NUM_BINS] = '{default: '0};

   rsp_type          steer_expect_q [$];
   scenario_row_type scenario [$];
   int               mismatch_count = 0;

   // Typed-in expectation for the transaction currently offered
   bit            pin_valid = 1'b0;
   rsp_type       pinned_rsp = '0;

   // Idling control and receiver hold-off
   int            send_idle_pct = 0;
   int            stall_pct = 0;
   int            hold_requests = 0;
   int            holds_served = 0;
   int            hold_left = 0;

   // Slowly drifting distance per bin, so that readings repeat and confirm
   int            scene_dist [NUM_BINS] = '{default: 1000};

   // Per-phase register settings
   int ph_block [RANDOM_PHASES] = '{220, 0, 4000, 4095, 1000, 300, 50, 2048};
   int ph_free [RANDOM_PHASES] = '{280, 0, 4000, 0, 1500, 200, 3900, 2049};
   int ph_confirm [RANDOM_PHASES] = '{2, 1, 3, 0, 3, 1, 2, 3};
   int ph_turn [RANDOM_PHASES] = '{150, 0, 255, 85, 200, 17, 1, 128};
   int ph_fwd [RANDOM_PHASES] = '{190, 255, 0, 170, 100, 34, 254, 127};
   int ph_idle [4] = '{0, 60, 0, 12};
   int ph_stall [4] = '{0, 0, 60, 12};

   obstacle_bin_hysteresis_steer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply a register write to the predictor copy
   task automatic apply_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         CSR_BLOCK_DISTANCE: blk_dist = data;
         CSR_FREE_DISTANCE: free_dist = data;
         CSR_CONFIRM_COUNT: confirm_cnt = data[COUNT_WIDTH-1:0];
         CSR_TURN_SPEED: turn_spd = data[SPEED_WIDTH-1:0];
         CSR_FORWARD_SPEED: fwd_spd = data[SPEED_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // Advance the bins by one sweep and work out the steering result
   task automatic predict_steer(input req_type r, output rsp_type res);
      logic [DIST_WIDTH-1:0] d [NUM_BINS];
      logic                  target;
      logic [NUM_BINS-1:0]   mask;
      logic [DIST_WIDTH-1:0] left_room;
      logic [DIST_WIDTH-1:0] right_room;
      int                    i;
      d[0] = r.dist_0;
      d[1] = r.dist_1;
      d[2] = r.dist_2;
      d[3] = r.dist_3;
      d[4] = r.dist_4;
      mask = '0;
      for (i = 0; i < NUM_BINS; i++) begin
         // a zero reading leaves the bin alone
         if (d[i] != '0) begin
            if (d[i] < blk_dist) begin
               target = 1'b1;
            end else if (d[i] > free_dist) begin
               target = 1'b0;
            end else begin
               target = bin_state[i];
            end
            if (target == bin_state[i]) begin
               pend_ticks[i] = '0;
            end else begin
               if (pend_state[i] == target) begin
                  if (pend_ticks[i] != TICKS_MAX) pend_ticks[i] = pend_ticks[i] + 1'b1;
               end else begin
                  pend_state[i] = target;
                  pend_ticks[i] = 2'd1;
               end
               if (pend_ticks[i] >= confirm_cnt) begin
                  bin_state[i] = target;
                  pend_ticks[i] = '0;
               end
            end
         end
         mask[i] = bin_state[i];
      end
      left_room = (d[1] > d[3]) ? d[1] : d[3];
      right_room = (d[2] > d[4]) ? d[2] : d[4];
      res.blocked_mask = mask;
      if (mask[2:0] != '0) begin
         res.decision = (left_room > right_room) ? DEC_LEFT : DEC_RIGHT;
         res.drive_speed = turn_spd;
      end else begin
         res.decision = DEC_FORWARD;
         res.drive_speed = fwd_spd;
      end
   endtask

   // Track register writes, predict on each request, check each result
   always @(posedge clock) begin : steer_monitor
      rsp_type predicted;
      rsp_type want;
      if (!reset) begin
         if (csr_wen) apply_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            predict_steer(req_payload, predicted);
            steer_expect_q.push_back(pin_valid ? pinned_rsp : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (steer_expect_q.size() == 0) begin
               $error("result with nothing expected: %h", rsp_payload);
               mismatch_count++;
            end else begin
               want = steer_expect_q.pop_front();
               if (rsp_payload.decision !== want.decision) begin
                  $error("decision: expected %0d, actual %0d",
                         want.decision, rsp_payload.decision);
                  mismatch_count++;
               end
               if (rsp_payload.drive_speed !== want.drive_speed) begin
                  $error("drive_speed: expected %0d, actual %0d",
                         want.drive_speed, rsp_payload.drive_speed);
                  mismatch_count++;
               end
               if (rsp_payload.blocked_mask !== want.blocked_mask) begin
                  $error("blocked_mask: expected %b, actual %b",
                         want.blocked_mask, rsp_payload.blocked_mask);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Receiver: random stall, or a long hold-off counted here
   always @(negedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic req_type mk_req(input int d0, input int d1, input int d2,
                                      input int d3, input int d4);
      req_type r;
      r.dist_0 = d0[DIST_WIDTH-1:0];
      r.dist_1 = d1[DIST_WIDTH-1:0];
      r.dist_2 = d2[DIST_WIDTH-1:0];
      r.dist_3 = d3[DIST_WIDTH-1:0];
      r.dist_4 = d4[DIST_WIDTH-1:0];
      return r;
   endfunction

   task automatic add_item(input int d0, input int d1, input int d2, input int d3,
                           input int d4, input int pinned,
                           input logic [DEC_WIDTH-1:0] dec,
                           input logic [SPEED_WIDTH-1:0] spd,
                           input logic [NUM_BINS-1:0] mask);
      scenario_row_type row;
      row.kind = ROW_ITEM;
      row.reg_index = '0;
      row.reg_data = '0;
      row.req = mk_req(d0, d1, d2, d3, d4);
      row.pinned = (pinned != 0);
      row.want.decision = dec;
      row.want.drive_speed = spd;
      row.want.blocked_mask = mask;
      scenario.push_back(row);
   endtask

   task automatic add_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                          input logic [CSR_DATA_WIDTH-1:0] data);
      scenario_row_type row;
      row.kind = ROW_REG;
      row.reg_index = idx;
      row.reg_data = data;
      row.req = '0;
      row.pinned = 1'b0;
      row.want = '0;
      scenario.push_back(row);
   endtask

   function automatic logic [DIST_WIDTH-1:0] clamp_dist(input int v);
      if (v < 1) return DIST_WIDTH'(1);
      if (v > 4095) return DIST_WIDTH'(4095);
      return v[DIST_WIDTH-1:0];
   endfunction

   // Pick a new resting distance, mostly around the thresholds
   function automatic int fresh_scene();
      case ($urandom_range(6))
         0: return int'(blk_dist) - 1;
         1: return int'(blk_dist);
         2: return int'(free_dist);
         3: return int'(free_dist) + 1;
         4: return $urandom_range(int'(blk_dist), 1);
         5: return $urandom_range(4095, int'(free_dist));
         default: return $urandom_range(4095, 1);
      endcase
   endfunction

   function automatic logic [DIST_WIDTH-1:0] draw_distance(input int bin);
      int roll;
      roll = $urandom_range(99);
      if (roll < 6) return '0;
      if (roll < 10) return DIST_WIDTH'($urandom_range(4095));
      if ($urandom_range(99) < 15) scene_dist[bin] = fresh_scene();
      return clamp_dist(scene_dist[bin] + $urandom_range(6) - 3);
   endfunction

   function automatic req_type random_req();
      return mk_req(draw_distance(0), draw_distance(1), draw_distance(2),
                    draw_distance(3), draw_distance(4));
   endfunction

   // Offer one transaction; starts and ends on a falling edge
   task automatic send_item(input req_type r, input bit pinned, input rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      pin_valid = pinned;
      pinned_rsp = want;
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic settle_block();
      req_valid <= 1'b0;
      while (steer_expect_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int k;
      int ph;
      int n;

      // Default thresholds: far, invalid, all-ones, then a change confirmed on its second tick
      add_item(4000, 4000, 4000, 4000, 4000, 1, DEC_FORWARD, RST_FORWARD_SPEED, 5'h00);
      add_item(0, 0, 0, 0, 0, 1, DEC_FORWARD, RST_FORWARD_SPEED, 5'h00);
      add_item(4095, 4095, 4095, 4095, 4095, 1, DEC_FORWARD, RST_FORWARD_SPEED, 5'h00);
      add_item(1, 1, 1, 1, 1, 1, DEC_FORWARD, RST_FORWARD_SPEED, 5'h00);
      add_item(1, 1, 1, 1, 1, 1, DEC_RIGHT, RST_TURN_SPEED, 5'h1F);
      add_item(0, 4000, 1, 0, 0, 0, DEC_FORWARD, '0, '0);
      // Readings exactly on the thresholds stay in the band
      add_item(220, 280, 219, 281, 279, 0, DEC_FORWARD, '0, '0);
      add_item(281, 281, 281, 281, 281, 0, DEC_FORWARD, '0, '0);
      add_item(281, 281, 281, 281, 281, 1, DEC_FORWARD, RST_FORWARD_SPEED, 5'h00);
      // Zero confirm count and overlapping thresholds: blocked wins at once
      add_reg(CSR_CONFIRM_COUNT, 12'd0);
      add_reg(CSR_BLOCK_DISTANCE, 12'd3000);
      add_reg(CSR_FREE_DISTANCE, 12'd100);
      add_item(2000, 2000, 2000, 2000, 2000, 1, DEC_RIGHT, RST_TURN_SPEED, 5'h1F);
      add_item(3500, 50, 3500, 0, 4095, 0, DEC_FORWARD, '0, '0);
      // Three-tick confirm with extreme speeds; a band reading clears the count
      add_reg(CSR_CONFIRM_COUNT, 12'd3);
      add_reg(CSR_BLOCK_DISTANCE, 12'd220);
      add_reg(CSR_FREE_DISTANCE, 12'd280);
      add_reg(CSR_TURN_SPEED, 12'd255);
      add_reg(CSR_FORWARD_SPEED, 12'd0);
      add_reg(CSR_UNUSED, 12'hFFF);
      add_item(4000, 4000, 4000, 4000, 4000, 0, DEC_FORWARD, '0, '0);
      add_item(4000, 4000, 4000, 4000, 4000, 0, DEC_FORWARD, '0, '0);
      add_item(4000, 4000, 4000, 4000, 4000, 1, DEC_FORWARD, 8'd0, 5'h00);
      add_item(100, 100, 100, 100, 100, 0, DEC_FORWARD, '0, '0);
      add_item(100, 100, 100, 100, 100, 0, DEC_FORWARD, '0, '0);
      add_item(250, 250, 250, 250, 250, 0, DEC_FORWARD, '0, '0);
      add_item(100, 100, 100, 100, 100, 0, DEC_FORWARD, '0, '0);
      add_item(100, 100, 100, 100, 100, 1, DEC_FORWARD, 8'd0, 5'h00);
      add_item(100, 100, 100, 100, 100, 1, DEC_RIGHT, 8'd255, 5'h1F);
      add_item(100, 4095, 100, 100, 100, 0, DEC_FORWARD, '0, '0);
      add_item(0, 0, 0, 4095, 4095, 0, DEC_FORWARD, '0, '0);

      // Hold reset, then release on a falling edge
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table
      for (k = 0; k < scenario.size(); k++) begin
         if (scenario[k].kind == ROW_REG) begin
            settle_block();
            write_reg(scenario[k].reg_index, scenario[k].reg_data);
         end else begin
            send_item(scenario[k].req, scenario[k].pinned, scenario[k].want);
         end
      end

      // Random phases: fresh registers each time, cycling through the idling patterns
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle_block();
         write_reg(CSR_BLOCK_DISTANCE, ph_block[ph][DIST_WIDTH-1:0]);
         write_reg(CSR_FREE_DISTANCE, ph_free[ph][DIST_WIDTH-1:0]);
         write_reg(CSR_CONFIRM_COUNT,
                   {10'($urandom_range(1023)), ph_confirm[ph][COUNT_WIDTH-1:0]});
         write_reg(CSR_TURN_SPEED, {4'($urandom_range(15)), ph_turn[ph][SPEED_WIDTH-1:0]});
         write_reg(CSR_FORWARD_SPEED, {4'($urandom_range(15)), ph_fwd[ph][SPEED_WIDTH-1:0]});
         send_idle_pct = ph_idle[ph % 4];
         stall_pct = ph_stall[ph % 4];
         // fill the block behind a long receiver hold-off
         if (ph == 4) hold_requests++;
         for (n = 0; n < ITEMS_PER_PHASE; n++) send_item(random_req(), 1'b0, '0);
      end

      settle_block();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && steer_expect_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Give up on a hung handshake
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/obhs_pkg.sv
rtl/obhs_bin.sv
rtl/obhs_steer.sv
rtl/obstacle_bin_hysteresis_steer.sv
rtl/obhs_checker.sv
dv/tb_obstacle_bin_hysteresis_steer.sv
